[rtl/bq4_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq4_pkg - shared types and constants of the four-lane biquad
// Sample and coefficient formats, MAC term codes, register indexes and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package bq4_pkg;

  // Samples are signed Q1.(SAMPLE_W-1); coefficients are signed Q3.15
  localparam int LANES     = 4;
  localparam int LANE_W    = $clog2(LANES);
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 15;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  // five products summed exactly, plus rounding headroom
  localparam int ACC_W     = PROD_W + 3;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X0 = 3'd0,
    REG_COEF_X1 = 3'd1,
    REG_COEF_X2 = 3'd2,
    REG_COEF_Y1 = 3'd3,
    REG_COEF_Y2 = 3'd4
  } cfg_reg_t;

  // One code per multiply-accumulate term of a lane, in issue order
  typedef enum logic [2:0] {
    TERM_X0 = 3'd0,
    TERM_X1 = 3'd1,
    TERM_X2 = 3'd2,
    TERM_Y1 = 3'd3,
    TERM_Y2 = 3'd4
  } term_t;

  // Controller to datapath command bundle
  typedef struct packed {
    logic              load_in;   // capture an accepted item
    logic              mac_en;    // issue one MAC term
    term_t             term;      // which term is issued
    logic              round_en;  // finish the lane: round, saturate, shift history
    logic [LANE_W-1:0] lane;      // lane being filtered
    logic              load_out;  // move finished lanes to the output register
  } dp_cmd_t;

endpackage

[rtl/bq4_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq4_in_if - input sample channel
// Valid/ready channel carrying four consecutive samples, oldest first.
// ----------------------------------------------------------------------------
interface bq4_in_if;
  logic              valid;
  logic              ready;
  bq4_pkg::sample_t  in_s0;
  bq4_pkg::sample_t  in_s1;
  bq4_pkg::sample_t  in_s2;
  bq4_pkg::sample_t  in_s3;

  modport source (output valid, output in_s0, output in_s1, output in_s2,
                  output in_s3, input ready);
  modport sink   (input valid, input in_s0, input in_s1, input in_s2,
                  input in_s3, output ready);
endinterface

[rtl/bq4_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq4_out_if - filtered sample channel
// Valid/ready channel carrying four filtered samples, oldest first.
// ----------------------------------------------------------------------------
interface bq4_out_if;
  logic              valid;
  logic              ready;
  bq4_pkg::sample_t  out_s0;
  bq4_pkg::sample_t  out_s1;
  bq4_pkg::sample_t  out_s2;
  bq4_pkg::sample_t  out_s3;

  modport source (output valid, output out_s0, output out_s1, output out_s2,
                  output out_s3, input ready);
  modport sink   (input valid, input out_s0, input out_s1, input out_s2,
                  input out_s3, output ready);
endinterface

[rtl/bq4_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq4_cfg_if - coefficient write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface bq4_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bq4_pkg::CFG_IDX_W-1:0]      index;
  logic [bq4_pkg::COEF_W-1:0]         data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bq4_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq4_dp - biquad datapath
// Coefficient registers, filter history, one shared 18x16 MAC with a product
// register, round-and-saturate stage and the output register.
// ----------------------------------------------------------------------------
module bq4_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bq4_pkg::dp_cmd_t              cmd,
  input  logic                          cfg_we,
  input  logic [bq4_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bq4_pkg::COEF_W-1:0]    cfg_data,
  input  bq4_pkg::sample_t              in_s0,
  input  bq4_pkg::sample_t              in_s1,
  input  bq4_pkg::sample_t              in_s2,
  input  bq4_pkg::sample_t              in_s3,
  output bq4_pkg::sample_t              out_s0,
  output bq4_pkg::sample_t              out_s1,
  output bq4_pkg::sample_t              out_s2,
  output bq4_pkg::sample_t              out_s3
);

  localparam int RQ_W = bq4_pkg::ACC_W - bq4_pkg::COEF_FRAC;
  localparam logic signed [bq4_pkg::ACC_W-1:0] RND_HALF =
    bq4_pkg::ACC_W'(2 ** (bq4_pkg::COEF_FRAC - 1));
  localparam logic signed [RQ_W-1:0] RQ_MAX = RQ_W'(2 ** (bq4_pkg::SAMPLE_W - 1) - 1);
  localparam logic signed [RQ_W-1:0] RQ_MIN = -RQ_MAX - RQ_W'(1);
  localparam bq4_pkg::sample_t SAT_MAX = bq4_pkg::SAMPLE_W'(2 ** (bq4_pkg::SAMPLE_W - 1) - 1);
  localparam bq4_pkg::sample_t SAT_MIN = -SAT_MAX - bq4_pkg::SAMPLE_W'(1);

  bq4_pkg::coef_t   gain_x0_r, coef_x1_r, coef_x2_r, coef_y1_r, coef_y2_r;
  bq4_pkg::sample_t x_back1_r, x_back2_r, y_back1_r, y_back2_r;
  bq4_pkg::sample_t x_in_r  [bq4_pkg::LANES];
  bq4_pkg::sample_t y_lane_r[bq4_pkg::LANES];
  bq4_pkg::sample_t out_r   [bq4_pkg::LANES];

  logic signed [bq4_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [bq4_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [bq4_pkg::ACC_W-1:0]  sum, rnd;
  logic signed [RQ_W-1:0]            rq;
  bq4_pkg::coef_t                    coef_sel;
  bq4_pkg::sample_t                  op_sel;
  bq4_pkg::sample_t                  x_cur;
  bq4_pkg::sample_t                  y_sat;

  // Coefficient registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_x0_r <= '0;
      coef_x1_r <= '0;
      coef_x2_r <= '0;
      coef_y1_r <= '0;
      coef_y2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bq4_pkg::REG_GAIN_X0: gain_x0_r <= cfg_data;
        bq4_pkg::REG_COEF_X1: coef_x1_r <= cfg_data;
        bq4_pkg::REG_COEF_X2: coef_x2_r <= cfg_data;
        bq4_pkg::REG_COEF_Y1: coef_y1_r <= cfg_data;
        bq4_pkg::REG_COEF_Y2: coef_y2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign x_cur = x_in_r[cmd.lane];

  // Select the coefficient and the sample for the issued term
  always_comb begin
    unique case (cmd.term)
      bq4_pkg::TERM_X0: begin coef_sel = gain_x0_r; op_sel = x_cur;     end
      bq4_pkg::TERM_X1: begin coef_sel = coef_x1_r; op_sel = x_back1_r; end
      bq4_pkg::TERM_X2: begin coef_sel = coef_x2_r; op_sel = x_back2_r; end
      bq4_pkg::TERM_Y1: begin coef_sel = coef_y1_r; op_sel = y_back1_r; end
      bq4_pkg::TERM_Y2: begin coef_sel = coef_y2_r; op_sel = y_back2_r; end
      default:          begin coef_sel = '0;        op_sel = '0;        end
    endcase
  end

  assign prod_nxt = bq4_pkg::PROD_W'(coef_sel * op_sel);

  // Accumulate the product of the previous term; the first term only multiplies
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.mac_en) begin
      case (cmd.term)
        bq4_pkg::TERM_X0: acc_nxt = acc_r;
        bq4_pkg::TERM_X1: acc_nxt = bq4_pkg::ACC_W'(prod_r);
        default:          acc_nxt = acc_r + bq4_pkg::ACC_W'(prod_r);
      endcase
    end
  end

  // Add the last product, round half up, saturate to the sample range
  always_comb begin
    sum = acc_r + bq4_pkg::ACC_W'(prod_r);
    rnd = sum + RND_HALF;
    rq  = rnd[bq4_pkg::ACC_W-1:bq4_pkg::COEF_FRAC];
    if (rq > RQ_MAX) begin
      y_sat = SAT_MAX;
    end else if (rq < RQ_MIN) begin
      y_sat = SAT_MIN;
    end else begin
      y_sat = rq[bq4_pkg::SAMPLE_W-1:0];
    end
  end

  // MAC registers
  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
  end

  // Filter history; the saturated output feeds back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_back1_r <= '0;
      x_back2_r <= '0;
      y_back1_r <= '0;
      y_back2_r <= '0;
    end else if (cmd.round_en) begin
      x_back2_r <= x_back1_r;
      x_back1_r <= x_cur;
      y_back2_r <= y_back1_r;
      y_back1_r <= y_sat;
    end
  end

  // Capture the item, collect lane results, load the output register
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_in_r[0] <= in_s0;
      x_in_r[1] <= in_s1;
      x_in_r[2] <= in_s2;
      x_in_r[3] <= in_s3;
    end
    if (cmd.round_en) begin
      y_lane_r[cmd.lane] <= y_sat;
    end
    if (cmd.load_out) begin
      out_r <= y_lane_r;
    end
  end

  assign out_s0 = out_r[0];
  assign out_s1 = out_r[1];
  assign out_s2 = out_r[2];
  assign out_s3 = out_r[3];

endmodule

[rtl/bq4_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bq4_ctrl - biquad sequencer
// Steps the shared MAC through five terms and one rounding step per lane,
// four lanes per item, and owns the input ready and output valid.
// ----------------------------------------------------------------------------
module bq4_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bq4_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ROUND,
    S_DONE
  } state_t;

  localparam logic [bq4_pkg::LANE_W-1:0] LAST_LANE = bq4_pkg::LANE_W'(bq4_pkg::LANES - 1);

  state_t                      state_r;
  bq4_pkg::term_t              term_r;
  logic [bq4_pkg::LANE_W-1:0]  lane_r;
  logic                        out_valid_r;
  logic                        slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Commands follow the state directly
  always_comb begin
    cmd          = '0;
    cmd.term     = term_r;
    cmd.lane     = lane_r;
    cmd.load_in  = (state_r == S_IDLE) && in_valid;
    cmd.mac_en   = (state_r == S_MUL);
    cmd.round_en = (state_r == S_ROUND);
    cmd.load_out = (state_r == S_DONE) && slot_free;
  end

  // Hold off new items while reset is applied
  assign in_ready  = (state_r == S_IDLE) && rst_n;
  assign out_valid = out_valid_r;

  // Sequence terms and lanes; hold the output until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= bq4_pkg::TERM_X0;
      lane_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_MUL;
            term_r  <= bq4_pkg::TERM_X0;
            lane_r  <= '0;
          end
        end
        S_MUL: begin
          if (term_r == bq4_pkg::TERM_Y2) begin
            state_r <= S_ROUND;
          end else begin
            term_r <= bq4_pkg::term_t'(term_r + 3'd1);
          end
        end
        S_ROUND: begin
          term_r <= bq4_pkg::TERM_X0;
          if (lane_r == LAST_LANE) begin
            state_r <= S_DONE;
          end else begin
            lane_r  <= lane_r + bq4_pkg::LANE_W'(1);
            state_r <= S_MUL;
          end
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // An accepted item starts at the first term of lane zero
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL && term_r == bq4_pkg::TERM_X0
                                && lane_r == '0))
    else $error("item accepted without starting lane zero");

  // The output register is only reloaded when its content has gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while still waiting");

  // A reload always presents a result in the next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  // Rounding follows the last term of a lane
  a_round_after_y2: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_en |-> ($past(state_r) == S_MUL && $past(term_r) == bq4_pkg::TERM_Y2))
    else $error("lane rounded before all terms were issued");

endmodule

[rtl/biquad_lowpass_df1_four_lane_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_lowpass_df1_four_lane_unit - four-lane Direct Form 1 biquad
// Top level: joins the sequencer, the datapath and the three channels.
// ----------------------------------------------------------------------------
// Second-order IIR filter, Direct Form 1, on Q1.15 samples with signed Q3.15
// coefficients written through the configuration channel (indexes 0 to 4:
// gain_x0, coef_x1, coef_x2, coef_y1, coef_y2; other indexes are dropped).
// Each item carries four consecutive samples, oldest first, and returns four
// filtered samples, each rounded half up and saturated, the saturated value
// feeding the recursion. One 18x16 multiplier with a product register serves
// all twenty terms of an item: five MAC steps and one rounding step a lane,
// so an item passes through acceptance, the working steps of its four lanes
// and the output load. The output register holds a finished item while the
// next one is accepted and filtered; a new item is accepted only after the
// last is loaded there, a load that waits until an untaken result has gone.
// Write coefficients only while the block is idle.
module biquad_lowpass_df1_four_lane_unit (
  input logic        clk,
  input logic        rst_n,
  bq4_in_if.sink     in_chan,
  bq4_out_if.source  out_chan,
  bq4_cfg_if.sink    cfg_chan
);

  bq4_pkg::dp_cmd_t cmd;
  logic             cfg_we;

  // Take coefficient writes whenever out of reset
  assign cfg_chan.ready = rst_n;
  assign cfg_we         = cfg_chan.valid && rst_n;

  bq4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  bq4_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_chan.data),
    .in_s0     (in_chan.in_s0),
    .in_s1     (in_chan.in_s1),
    .in_s2     (in_chan.in_s2),
    .in_s3     (in_chan.in_s3),
    .out_s0    (out_chan.out_s0),
    .out_s1    (out_chan.out_s1),
    .out_s2    (out_chan.out_s2),
    .out_s3    (out_chan.out_s3)
  );

endmodule

[sim/tb_biquad_lowpass_df1_four_lane_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_biquad_lowpass_df1_four_lane_unit - self-checking bench for the biquad
// Loads coefficient sets through the configuration channel and feeds blocks
// of four samples with random gaps and output back-pressure. A bit-true
// Direct Form 1 filter in a scoreboard class predicts every filtered block,
// and each one is compared lane by lane as it leaves the block.
// ----------------------------------------------------------------------------
module tb_biquad_lowpass_df1_four_lane_unit;

  // four samples of one item, lane 0 (oldest) in the low bits
  typedef bq4_pkg::sample_t [bq4_pkg::LANES-1:0] quad_t;

  localparam int     CLK_HALF        = 4;
  localparam int     RESET_CYCLES    = 8;
  localparam int     DRAIN_CYCLES    = 40;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam int     RANDOM_ITEMS    = 1950;
  localparam longint SAMPLE_MAX      = (longint'(1) << (bq4_pkg::SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN      = -SAMPLE_MAX - 1;
  localparam longint ROUND_HALF      = longint'(1) << (bq4_pkg::COEF_FRAC - 1);
  localparam bq4_pkg::coef_t UNITY     = bq4_pkg::coef_t'(1 << bq4_pkg::COEF_FRAC);
  localparam bq4_pkg::coef_t HALF_GAIN = bq4_pkg::coef_t'(1 << (bq4_pkg::COEF_FRAC - 1));
  localparam bq4_pkg::coef_t COEF_MAX  = bq4_pkg::coef_t'((1 << (bq4_pkg::COEF_W - 1)) - 1);
  localparam bq4_pkg::coef_t COEF_MIN  = bq4_pkg::coef_t'(-(1 << (bq4_pkg::COEF_W - 1)));
  // indexes past the last coefficient are decoded as nothing
  localparam logic [bq4_pkg::CFG_IDX_W-1:0] FIRST_SPARE_REG =
    bq4_pkg::CFG_IDX_W'(bq4_pkg::REG_COEF_Y2 + 1);
  localparam logic [bq4_pkg::CFG_IDX_W-1:0] LAST_SPARE_REG  = '1;

  // --------------------------------------------------------------------------
  // Bit-true filter and store of expected output blocks
  // --------------------------------------------------------------------------
  class biquad_scoreboard;
    bq4_pkg::coef_t   gain_x0, coef_x1, coef_x2, coef_y1, coef_y2;
    bq4_pkg::sample_t x_back1, x_back2, y_back1, y_back2;
    quad_t            expected_q[$];
    int unsigned      n_errors;

    function new();
      gain_x0  = '0;
      coef_x1  = '0;
      coef_x2  = '0;
      coef_y1  = '0;
      coef_y2  = '0;
      x_back1  = '0;
      x_back2  = '0;
      y_back1  = '0;
      y_back2  = '0;
      n_errors = 0;
    endfunction

    function void write_reg(logic [bq4_pkg::CFG_IDX_W-1:0] idx, bq4_pkg::coef_t val);
      case (idx)
        bq4_pkg::REG_GAIN_X0: gain_x0 = val;
        bq4_pkg::REG_COEF_X1: coef_x1 = val;
        bq4_pkg::REG_COEF_X2: coef_x2 = val;
        bq4_pkg::REG_COEF_Y1: coef_y1 = val;
        bq4_pkg::REG_COEF_Y2: coef_y2 = val;
        default: ;
      endcase
    endfunction

    // exact sum, round half up, saturate; the saturated value feeds back
    function bq4_pkg::sample_t filter_sample(bq4_pkg::sample_t x);
      longint acc;
      longint r;
      acc = longint'(gain_x0) * longint'(x)
          + longint'(coef_x1) * longint'(x_back1)
          + longint'(coef_x2) * longint'(x_back2)
          + longint'(coef_y1) * longint'(y_back1)
          + longint'(coef_y2) * longint'(y_back2);
      r = (acc + ROUND_HALF) >>> bq4_pkg::COEF_FRAC;
      if (r > SAMPLE_MAX) begin
        r = SAMPLE_MAX;
      end else if (r < SAMPLE_MIN) begin
        r = SAMPLE_MIN;
      end
      x_back2 = x_back1;
      x_back1 = x;
      y_back2 = y_back1;
      y_back1 = bq4_pkg::sample_t'(r);
      return bq4_pkg::sample_t'(r);
    endfunction

    function void note_input(quad_t q);
      quad_t want;
      for (int lane = 0; lane < bq4_pkg::LANES; lane++) begin
        want[lane] = filter_sample(q[lane]);
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(quad_t got);
      quad_t want;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t ns: unexpected item, expected none, got %0d %0d %0d %0d", $time,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
        return;
      end
      want = expected_q.pop_front();
      for (int lane = 0; lane < bq4_pkg::LANES; lane++) begin
        if (got[lane] !== want[lane]) begin
          n_errors++;
          $display("%0t ns: out_s%0d expected %0d, got %0d", $time, lane,
                   $signed(want[lane]), $signed(got[lane]));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bq4_in_if  in_chan ();
  bq4_out_if out_chan ();
  bq4_cfg_if cfg_chan ();

  biquad_lowpass_df1_four_lane_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  biquad_scoreboard sb;
  bit send_idle;
  bit recv_idle;
  bit hold_off_req;
  bit run_started;

  // Clock
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #12ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(41, 100);
  endfunction

  function automatic quad_t quad_of(int s0, int s1, int s2, int s3);
    return {bq4_pkg::sample_t'(s3), bq4_pkg::sample_t'(s2), bq4_pkg::sample_t'(s1),
            bq4_pkg::sample_t'(s0)};
  endfunction

  // full range mostly, then quiet signals and the extremes
  function automatic bq4_pkg::sample_t rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return bq4_pkg::sample_t'($urandom);
    if (r < 85) return bq4_pkg::sample_t'(int'($urandom_range(0, 4095)) - 2048);
    case ($urandom_range(0, 4))
      0:       return bq4_pkg::sample_t'(SAMPLE_MAX);
      1:       return bq4_pkg::sample_t'(SAMPLE_MIN);
      2:       return bq4_pkg::sample_t'(1);
      3:       return bq4_pkg::sample_t'(-1);
      default: return '0;
    endcase
  endfunction

  function automatic bq4_pkg::coef_t extreme_coef();
    case ($urandom_range(0, 2))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      default: return '0;
    endcase
  endfunction

  // Offer one item, note it once accepted, then idle for gap cycles
  task automatic send_quad(quad_t q, int unsigned gap);
    in_chan.valid <= 1'b1;
    in_chan.in_s0 <= q[0];
    in_chan.in_s1 <= q[1];
    in_chan.in_s2 <= q[2];
    in_chan.in_s3 <= q[3];
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sb.note_input(q);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [bq4_pkg::CFG_IDX_W-1:0] idx, bq4_pkg::coef_t val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    sb.write_reg(idx, val);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_coefs(bq4_pkg::coef_t g, bq4_pkg::coef_t x1, bq4_pkg::coef_t x2,
                            bq4_pkg::coef_t y1, bq4_pkg::coef_t y2);
    write_reg(bq4_pkg::REG_GAIN_X0, g);
    write_reg(bq4_pkg::REG_COEF_X1, x1);
    write_reg(bq4_pkg::REG_COEF_X2, x2);
    write_reg(bq4_pkg::REG_COEF_Y1, y1);
    write_reg(bq4_pkg::REG_COEF_Y2, y2);
  endtask

  // Stop offering, drain every expected item, then let the datapath settle
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_random_coefs();
    int unsigned    kind;
    bq4_pkg::coef_t b0;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      // low-pass shape: b0, 2*b0, b0 with feedback near the unit circle
      b0 = bq4_pkg::coef_t'($urandom_range(50, 6000));
      load_coefs(b0, bq4_pkg::coef_t'(2 * b0), b0,
                 bq4_pkg::coef_t'($urandom_range(20000, 62000)),
                 bq4_pkg::coef_t'(-int'($urandom_range(4000, 30000))));
    end else if (kind < 9) begin
      load_coefs(bq4_pkg::coef_t'($urandom), bq4_pkg::coef_t'($urandom),
                 bq4_pkg::coef_t'($urandom), bq4_pkg::coef_t'($urandom),
                 bq4_pkg::coef_t'($urandom));
    end else begin
      load_coefs(extreme_coef(), extreme_coef(), extreme_coef(), extreme_coef(),
                 extreme_coef());
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    out_chan.ready <= 1'b0;
    wait (run_started);
    forever begin
      if (hold_off_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (recv_idle && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat (pick_gap(1'b1) + 1) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Check every item that leaves the block
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      sb.check_result({out_chan.out_s3, out_chan.out_s2, out_chan.out_s1, out_chan.out_s0});
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int sent;
    int phase;
    int n_items;
    sb = new();
    sent  = 0;
    phase = 0;
    send_idle    = 1'b0;
    recv_idle    = 1'b0;
    hold_off_req = 1'b0;
    run_started  = 1'b0;
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.in_s0  <= '0;
    in_chan.in_s1  <= '0;
    in_chan.in_s2  <= '0;
    in_chan.in_s3  <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= '0;
    cfg_chan.data  <= '0;

    // Hold reset, then release it once
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_started = 1'b1;
    recv_idle   = 1'b1;

    // Unity gain passes the extremes straight through
    load_coefs(UNITY, '0, '0, '0, '0);
    send_quad(quad_of(0, 0, 0, 0), pick_gap(1'b1));
    send_quad(quad_of(32767, -32768, 1, -1), pick_gap(1'b1));
    send_quad(quad_of(-32768, 32767, -1, 1), pick_gap(1'b1));
    wait_idle();

    // Writes to spare indexes must leave the coefficients alone
    write_reg(FIRST_SPARE_REG, COEF_MAX);
    write_reg(LAST_SPARE_REG, '0);
    send_quad(quad_of(100, -200, 300, -400), pick_gap(1'b1));
    wait_idle();

    // Half gain lands exactly on rounding ties, both signs
    load_coefs(HALF_GAIN, '0, '0, '0, '0);
    send_quad(quad_of(1, -1, 3, -3), pick_gap(1'b1));
    send_quad(quad_of(32767, -32768, -32767, 5), pick_gap(1'b1));
    wait_idle();

    // Extreme coefficients drive the sum into saturation both ways
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_quad(quad_of(32767, -32768, 32767, -32768), pick_gap(1'b1));
    send_quad(quad_of(-32768, -32768, 32767, 32767), pick_gap(1'b1));
    send_quad(quad_of(0, 0, 0, 0), pick_gap(1'b1));
    send_quad(quad_of(1, 1, 1, 1), pick_gap(1'b1));
    wait_idle();

    load_coefs(COEF_MIN, '0, '0, COEF_MAX, COEF_MIN);
    send_quad(quad_of(32767, 32767, -32768, 0), pick_gap(1'b1));
    send_quad(quad_of(0, 0, 0, 0), pick_gap(1'b1));
    send_quad(quad_of(-1, -1, -1, -1), pick_gap(1'b1));
    wait_idle();

    // Delayed input alone, then a low-pass step response through all terms
    load_coefs('0, UNITY, HALF_GAIN, '0, '0);
    send_quad(quad_of(10, 20, 30, 40), pick_gap(1'b1));
    send_quad(quad_of(-50, 60, -70, 80), pick_gap(1'b1));
    wait_idle();

    load_coefs(bq4_pkg::coef_t'(2000), bq4_pkg::coef_t'(4000), bq4_pkg::coef_t'(2000),
               bq4_pkg::coef_t'(58000), bq4_pkg::coef_t'(-26000));
    send_quad(quad_of(16384, 16384, 16384, 16384), pick_gap(1'b1));
    send_quad(quad_of(16384, 16384, 16384, 16384), pick_gap(1'b1));
    send_quad(quad_of(-16384, -16384, -16384, -16384), pick_gap(1'b1));
    wait_idle();

    // Random phases, each with its own coefficient set and idling pattern
    while (sent < RANDOM_ITEMS) begin
      load_random_coefs();
      if ($urandom_range(0, 2) == 0) begin
        write_reg(bq4_pkg::CFG_IDX_W'($urandom_range(LAST_SPARE_REG, FIRST_SPARE_REG)),
                  bq4_pkg::coef_t'($urandom));
      end
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      // stall the result side for a long stretch while items keep coming
      if (phase == 1 || phase == 5) begin
        send_idle    = 1'b0;
        hold_off_req = 1'b1;
      end
      n_items = $urandom_range(80, 240);
      // stop at the planned item count
      if (n_items > RANDOM_ITEMS - sent) begin
        n_items = RANDOM_ITEMS - sent;
      end
      repeat (n_items) begin
        send_quad({rand_sample(), rand_sample(), rand_sample(), rand_sample()},
                  pick_gap(send_idle));
        sent++;
      end
      wait_idle();
      phase++;
    end

    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[biquad_lowpass_df1_four_lane_unit.f]
rtl/bq4_pkg.sv
rtl/bq4_in_if.sv
rtl/bq4_out_if.sv
rtl/bq4_cfg_if.sv
rtl/bq4_dp.sv
rtl/bq4_ctrl.sv
rtl/biquad_lowpass_df1_four_lane_unit.sv
sim/tb_biquad_lowpass_df1_four_lane_unit.sv
